// ----- rtl/core/ntab_pkg.sv -----
// ---------------------------------------------------------------------------
// Neighbor table package
// Shared sizes, field codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ntab_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ID_WIDTH      = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int TTL_W         = 8;
    localparam int LEN_W         = 16;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int OUT_CNT_W     = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [LEN_W-1:0] ID_BYTES = LEN_W'(ID_WIDTH / 8);

    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = '0;
    localparam logic [TTL_W-1:0]  REFRESH_TTL_RESET = 8'd128;
    localparam logic [TTL_W-1:0]  AGE_STEP_RESET    = 8'd10;

    localparam logic [FUNC_W-1:0] FUNC_BEACON = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TTL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_STEP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OWN_BEACON = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NEW        = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_REFRESHED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL_DROP  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_TICK_DONE  = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_HIT        = 3'd6;
    localparam logic [STATUS_W-1:0] STATUS_MISS       = 3'd7;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } ntab_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } ntab_stat_t;

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        if ({5'd0, v} > (CNT_W + 5)'(31)) begin
            return 5'd31;
        end else begin
            return OUT_CNT_W'(v);
        end
    endfunction

endpackage

// ----- rtl/core/ntab_ctrl.sv -----
// ---------------------------------------------------------------------------
// Neighbor table controller
// Sequences one beat through load, table scan and result write-back.
// ---------------------------------------------------------------------------
module ntab_ctrl
    import ntab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ntab_stat_t stat,
    output ntab_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    always_comb begin
        cmd       = '0;
        cmd.load  = s_valid && s_ready_reg;
        cmd.step  = (state_reg == ST_SCAN);
        cmd.apply = (state_reg == ST_APPLY) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_SCAN;
                        s_ready_reg <= 1'b0;
                    end else begin
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (stat.scan_last) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (stat.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ----- rtl/core/ntab_dp.sv -----
// ---------------------------------------------------------------------------
// Neighbor table datapath
// Holds the configuration, the entry table, the scan unit and the result register.
// ---------------------------------------------------------------------------
module ntab_dp
    import ntab_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [ID_WIDTH-1:0]   s_node_id,
    input  logic [ADDR_W-1:0]     s_sender_address,
    input  logic [LEN_W-1:0]      s_payload_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ADDR_W-1:0]     m_found_address,
    output logic [OUT_CNT_W-1:0]  m_removed_count,
    output logic [OUT_CNT_W-1:0]  m_entry_count,
    input  ntab_cmd_t             cmd,
    output ntab_stat_t            stat
);

    logic [ADDR_W-1:0] own_address_reg;
    logic [TTL_W-1:0]  refresh_ttl_reg;
    logic [TTL_W-1:0]  age_step_reg;

    logic                entry_valid_reg   [TABLE_ENTRIES];
    logic [ID_WIDTH-1:0] entry_id_reg      [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   entry_address_reg [TABLE_ENTRIES];
    logic [TTL_W-1:0]    entry_ttl_reg     [TABLE_ENTRIES];

    logic [FUNC_W-1:0]   func_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;

    logic [IDX_W-1:0]  scan_idx_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [ADDR_W-1:0] match_addr_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [CNT_W-1:0]  removed_reg;
    logic [CNT_W-1:0]  count_reg;

    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [ADDR_W-1:0]    found_reg;
    logic [OUT_CNT_W-1:0] removed_out_reg;
    logic [OUT_CNT_W-1:0] count_out_reg;

    logic                 cur_valid;
    logic                 cur_hit;
    logic                 cur_expire;
    logic                 is_tick;
    logic                 bcn_bad_len;
    logic                 bcn_own;
    logic                 bcn_refresh;
    logic                 bcn_new;
    logic [STATUS_W-1:0]  status_next;
    logic [CNT_W-1:0]     count_next;

    assign cur_valid  = entry_valid_reg[scan_idx_reg];
    assign cur_hit    = cur_valid && (entry_id_reg[scan_idx_reg] == id_reg);
    assign cur_expire = (entry_ttl_reg[scan_idx_reg] <= age_step_reg);
    assign is_tick    = (func_reg == FUNC_TICK);

    assign bcn_bad_len = (len_reg != ID_BYTES);
    assign bcn_own     = (addr_reg == own_address_reg);
    assign bcn_refresh = (func_reg == FUNC_BEACON) && !bcn_bad_len && !bcn_own
                         && match_found_reg;
    assign bcn_new     = (func_reg == FUNC_BEACON) && !bcn_bad_len && !bcn_own
                         && !match_found_reg && free_found_reg;

    always_comb begin
        case (func_reg)
            FUNC_BEACON: begin
                if (bcn_bad_len) begin
                    status_next = STATUS_BAD_LENGTH;
                end else if (bcn_own) begin
                    status_next = STATUS_OWN_BEACON;
                end else if (match_found_reg) begin
                    status_next = STATUS_REFRESHED;
                end else if (free_found_reg) begin
                    status_next = STATUS_NEW;
                end else begin
                    status_next = STATUS_FULL_DROP;
                end
            end
            FUNC_TICK:   status_next = STATUS_TICK_DONE;
            FUNC_LOOKUP: status_next = match_found_reg ? STATUS_HIT : STATUS_MISS;
            default:     status_next = STATUS_MISS;
        endcase
    end

    assign count_next = bcn_new ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= OWN_ADDRESS_RESET;
            refresh_ttl_reg <= REFRESH_TTL_RESET;
            age_step_reg    <= AGE_STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_address_reg <= cfg_wdata;
                CFG_REFRESH_TTL: refresh_ttl_reg <= cfg_wdata[TTL_W-1:0];
                CFG_AGE_STEP:    age_step_reg    <= cfg_wdata[TTL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_valid_reg[i] <= 1'b0;
            end
            count_reg <= '0;
        end else if (cmd.step) begin
            if (is_tick && cur_valid && cur_expire) begin
                entry_valid_reg[scan_idx_reg] <= 1'b0;
                count_reg                     <= count_reg - CNT_W'(1);
            end
        end else if (cmd.apply) begin
            if (bcn_new) begin
                entry_valid_reg[free_idx_reg] <= 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (is_tick && cur_valid && !cur_expire) begin
                entry_ttl_reg[scan_idx_reg] <= entry_ttl_reg[scan_idx_reg] - age_step_reg;
            end
        end else if (cmd.apply) begin
            if (bcn_refresh) begin
                entry_ttl_reg[match_idx_reg] <= refresh_ttl_reg;
            end else if (bcn_new) begin
                entry_ttl_reg[free_idx_reg]     <= refresh_ttl_reg;
                entry_id_reg[free_idx_reg]      <= id_reg;
                entry_address_reg[free_idx_reg] <= addr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg        <= s_func;
            id_reg          <= s_node_id;
            addr_reg        <= s_sender_address;
            len_reg         <= s_payload_length;
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            match_addr_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            removed_reg     <= '0;
        end else if (cmd.step) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (!match_found_reg && cur_hit) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= scan_idx_reg;
                match_addr_reg  <= entry_address_reg[scan_idx_reg];
            end
            if (!free_found_reg && !cur_valid) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
            if (is_tick && cur_valid && cur_expire) begin
                removed_reg <= removed_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            status_reg      <= status_next;
            found_reg       <= (func_reg == FUNC_LOOKUP && match_found_reg)
                               ? match_addr_reg : '0;
            removed_out_reg <= is_tick ? sat_count(removed_reg) : '0;
            count_out_reg   <= sat_count(count_next);
        end
    end

    assign stat.scan_last = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_found_address = found_reg;
    assign m_removed_count = removed_out_reg;
    assign m_entry_count   = count_out_reg;

endmodule

// ----- rtl/core/neighbor_table_with_aging_unit.sv -----
// ---------------------------------------------------------------------------
// Neighbor table with aging
// Keeps node id, address and time-to-live for up to sixteen neighbors.
//
// The input channel takes one beat per item: a beacon, an aging tick or a
// lookup. The result channel returns exactly one beat per item with a status,
// the found address, the removed count and the entry count after the item.
// Each item is scanned over the table one entry per cycle. A new item is
// accepted in the cycle after the previous result is written to the output
// register, so the block does not take an item before the last one is done.
// The output register holds a finished result while the next item is taken.
// If the receiver stalls, the next item completes its scan and then waits
// until the held result is taken.
// Reset clears all entries and loads the register defaults: own address 0,
// refresh TTL 128 and age step 10. Configuration is to be written only while
// idle; the block itself does not enforce this.
module neighbor_table_with_aging_unit
    import ntab_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [ID_WIDTH-1:0]   s_node_id,
    input  logic [ADDR_W-1:0]     s_sender_address,
    input  logic [LEN_W-1:0]      s_payload_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ADDR_W-1:0]     m_found_address,
    output logic [OUT_CNT_W-1:0]  m_removed_count,
    output logic [OUT_CNT_W-1:0]  m_entry_count
);

    ntab_cmd_t  cmd;
    ntab_stat_t stat;

    ntab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ntab_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_func           (s_func),
        .s_node_id        (s_node_id),
        .s_sender_address (s_sender_address),
        .s_payload_length (s_payload_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_address  (m_found_address),
        .m_removed_count  (m_removed_count),
        .m_entry_count    (m_entry_count),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Neighbor table with aging: block-level testbench
// Drives beacons, aging ticks and lookups into the table over a
// valid/ready channel. A behavioral copy of the table, with its own register
// values, predicts every result beat, and each result is checked field by
// field. Register settings change between phases while the block is idle.
// Both channels idle at random, and the receiver holds off once for a long
// stretch so that the block stalls its input.
// ---------------------------------------------------------------------------
module tb
    import ntab_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int NODE_POOL      = 24;
    localparam int PHASE_ITEMS    = 125;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    found;
        logic [OUT_CNT_W-1:0] removed;
        logic [OUT_CNT_W-1:0] count;
    } ntab_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func = '0;
    logic [ID_WIDTH-1:0]   s_node_id = '0;
    logic [ADDR_W-1:0]     s_sender_address = '0;
    logic [LEN_W-1:0]      s_payload_length = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [ADDR_W-1:0]     m_found_address;
    logic [OUT_CNT_W-1:0]  m_removed_count;
    logic [OUT_CNT_W-1:0]  m_entry_count;

    neighbor_table_with_aging_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_node_id        (s_node_id),
        .s_sender_address (s_sender_address),
        .s_payload_length (s_payload_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_address  (m_found_address),
        .m_removed_count  (m_removed_count),
        .m_entry_count    (m_entry_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Behavioral copy of the table and its registers.
    logic                tbl_valid [TABLE_ENTRIES];
    logic [ID_WIDTH-1:0] tbl_id    [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   tbl_addr  [TABLE_ENTRIES];
    logic [TTL_W-1:0]    tbl_ttl   [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   own_addr_cfg = OWN_ADDRESS_RESET;
    logic [TTL_W-1:0]    refresh_cfg  = REFRESH_TTL_RESET;
    logic [TTL_W-1:0]    step_cfg     = AGE_STEP_RESET;

    ntab_reply_t         expected_replies [$];
    logic [ID_WIDTH-1:0] node_pool [NODE_POOL];

    int src_idle_pct  = 26;
    int sink_idle_pct = 26;
    int hold_request  = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int replies_seen  = 0;
    int settings_used = 1;
    int aged_out      = 0;
    int quiet_cycles  = 0;
    int status_seen [8];

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            status_seen[i] = 0;
        end
    end

    function automatic logic [OUT_CNT_W-1:0] clip_count(input int v);
        return (v > 31) ? OUT_CNT_W'(31) : OUT_CNT_W'(v);
    endfunction

    function automatic int find_node(input logic [ID_WIDTH-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic ntab_reply_t table_predict(input logic [FUNC_W-1:0] f,
                                                  input logic [ID_WIDTH-1:0] id,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [LEN_W-1:0] len);
        ntab_reply_t r;
        int k;
        int removed;
        int live;
        r.status = STATUS_MISS;
        r.found  = '0;
        removed  = 0;
        live     = 0;
        case (f)
            FUNC_BEACON: begin
                if (len != ID_BYTES) begin
                    r.status = STATUS_BAD_LENGTH;
                end else if (addr == own_addr_cfg) begin
                    r.status = STATUS_OWN_BEACON;
                end else begin
                    k = find_node(id);
                    if (k >= 0) begin
                        tbl_ttl[k] = refresh_cfg;
                        r.status = STATUS_REFRESHED;
                    end else begin
                        for (int i = 0; i < TABLE_ENTRIES && k < 0; i++) begin
                            if (!tbl_valid[i]) begin
                                k = i;
                            end
                        end
                        if (k < 0) begin
                            r.status = STATUS_FULL_DROP;
                        end else begin
                            tbl_valid[k] = 1'b1;
                            tbl_id[k]    = id;
                            tbl_addr[k]  = addr;
                            tbl_ttl[k]   = refresh_cfg;
                            r.status = STATUS_NEW;
                        end
                    end
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_ttl[i] <= step_cfg) begin
                            tbl_valid[i] = 1'b0;
                            removed++;
                        end else begin
                            tbl_ttl[i] = tbl_ttl[i] - step_cfg;
                        end
                    end
                end
                r.status = STATUS_TICK_DONE;
            end
            FUNC_LOOKUP: begin
                k = find_node(id);
                if (k >= 0) begin
                    r.status = STATUS_HIT;
                    r.found  = tbl_addr[k];
                end
            end
            default: ;
        endcase
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                live++;
            end
        end
        r.removed = clip_count(removed);
        r.count   = clip_count(live);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    // Result checking and input prediction share one block so that the result
    // check always runs before the input prediction.
    always @(posedge aclk) begin : reply_check
        ntab_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (!$isunknown(m_status)) begin
                status_seen[m_status]++;
            end
            if (!$isunknown(m_removed_count)) begin
                aged_out += m_removed_count;
            end
            if (expected_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: result beat with nothing expected, status %0h",
                             $time, m_status);
                end
            end else begin
                want = expected_replies.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("found_address", want.found, m_found_address);
                check_field("removed_count", 32'(want.removed), 32'(m_removed_count));
                check_field("entry_count", 32'(want.count), 32'(m_entry_count));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            items_sent++;
            expected_replies = {expected_replies,
                                table_predict(s_func, s_node_id,
                                              s_sender_address, s_payload_length)};
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin : receiver
        int hold_left;
        if (hold_request != 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ID_WIDTH-1:0] id,
                             input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= f;
        s_node_id        <= id;
        s_sender_address <= addr;
        s_payload_length <= len;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        case (idx)
            CFG_OWN_ADDRESS: own_addr_cfg = d;
            CFG_REFRESH_TTL: refresh_cfg  = d[TTL_W-1:0];
            CFG_AGE_STEP:    step_cfg     = d[TTL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [ADDR_W-1:0] own, input logic [TTL_W-1:0] ttl,
                                  input logic [TTL_W-1:0] step);
        wait_drained();
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_REFRESH_TTL, CFG_DATA_W'(ttl));
        write_reg(CFG_AGE_STEP, CFG_DATA_W'(step));
        settings_used++;
    endtask

    task automatic send_random_item();
        logic [ID_WIDTH-1:0] id;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        int pick;
        id   = ($urandom_range(99) < 80) ? node_pool[$urandom_range(NODE_POOL - 1)] : $urandom;
        addr = ($urandom_range(99) < 8) ? own_addr_cfg : $urandom;
        pick = $urandom_range(99);
        if (pick < 85) begin
            len = ID_BYTES;
        end else if (pick < 92) begin
            len = ID_BYTES + LEN_W'($urandom_range(1)) * 2 - 1;
        end else begin
            len = LEN_W'($urandom_range(65535));
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_item(FUNC_BEACON, id, addr, len);
        end else if (pick < 72) begin
            send_item(FUNC_TICK, $urandom, $urandom, LEN_W'($urandom_range(65535)));
        end else begin
            send_item(FUNC_LOOKUP, id, $urandom, LEN_W'($urandom_range(65535)));
        end
    endtask

    // Default registers: own address is zero, so a beacon from address zero
    // is our own unless its length is wrong first.
    task automatic test_empty_table();
        send_item(FUNC_LOOKUP, '0, '0, ID_BYTES);
        send_item(FUNC_TICK, '1, '1, '1);
        send_item(FUNC_BEACON, node_pool[2], '0, ID_BYTES);
        send_item(FUNC_BEACON, node_pool[2], '0, ID_BYTES + LEN_W'(1));
    endtask

    task automatic test_beacon_filters();
        send_item(FUNC_BEACON, node_pool[2], 32'h0a00_0001, '0);
        send_item(FUNC_BEACON, node_pool[2], 32'h0a00_0001, '1);
        wait_drained();
        write_reg(CFG_OWN_ADDRESS, '1);
        settings_used++;
        send_item(FUNC_BEACON, node_pool[2], '1, ID_BYTES);
    endtask

    // Fill every slot, overflow by one, then refresh a known node with a new
    // address: the stored address must stay the old one.
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            send_item(FUNC_BEACON, node_pool[i], (i == 0) ? '0 : ADDR_W'($urandom), ID_BYTES);
        end
        send_item(FUNC_BEACON, node_pool[TABLE_ENTRIES], 32'hc0a8_0101, ID_BYTES);
        send_item(FUNC_BEACON, node_pool[3], 32'hc0a8_0202, ID_BYTES);
        send_item(FUNC_LOOKUP, node_pool[3], '0, '0);
    endtask

    // An entry expires when its TTL is at most the step, and not before.
    task automatic test_aging();
        wait_drained();
        write_reg(CFG_AGE_STEP, CFG_DATA_W'(8'd127));
        send_item(FUNC_TICK, '0, '0, '0);
        wait_drained();
        write_reg(CFG_AGE_STEP, CFG_DATA_W'(8'd1));
        send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_LOOKUP, node_pool[3], '0, '0);
        settings_used++;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_settings('1, 8'd255, 8'd1);
                1: apply_settings($urandom, 8'd1, 8'd255);
                2: apply_settings($urandom, 8'd128, 8'd10);
                3: apply_settings('0, 8'd40, 8'd10);
                4: apply_settings($urandom, 8'($urandom_range(1, 255)),
                                  8'($urandom_range(1, 255)));
                default: apply_settings($urandom, 8'($urandom_range(20, 255)),
                                        8'($urandom_range(1, 20)));
            endcase
            src_idle_pct  = (phase == 3) ? 0 : 26;
            sink_idle_pct = (phase == 3) ? 0 : 26;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end
        src_idle_pct  = 26;
        sink_idle_pct = 26;
    endtask

    // The receiver stops taking results while the sender keeps offering items
    // without gaps, so the block has to stall its input.
    task automatic test_backpressure();
        wait_drained();
        src_idle_pct = 0;
        hold_request = 1;
        for (int n = 0; n < 30; n++) begin
            send_random_item();
        end
        src_idle_pct = 26;
    endtask

    initial begin
        for (int i = 0; i < NODE_POOL; i++) begin
            node_pool[i] = $urandom;
        end
        node_pool[0] = '0;
        node_pool[1] = '1;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_beacon_filters();
        test_table_fill();
        test_aging();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (30) @(posedge aclk);
        $display("summary: %0d items and %0d results over %0d register settings",
                 items_sent, replies_seen, settings_used);
        $display("summary: new %0d, refreshed %0d, table full %0d, hits %0d, %s",
                 status_seen[STATUS_NEW], status_seen[STATUS_REFRESHED],
                 status_seen[STATUS_FULL_DROP], status_seen[STATUS_HIT],
                 $sformatf("misses %0d, %0d aged out", status_seen[STATUS_MISS],
                           aged_out));
        if (fail_count == 0 && expected_replies.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
